// ===== rtl/llrkp_pkg.sv =====
package llrkp_pkg;

  localparam int MaxElems = 4096;
  localparam int SampleW  = 16;
  localparam int FracBits = 10;
  localparam int IdxW     = $clog2(MaxElems);
  localparam int CntW     = IdxW + 1;
  localparam int CfgW     = 13;
  localparam int CfgIdxW  = 2;
  localparam int PrefW    = 2 * CfgW;
  localparam int SumW     = 28;
  localparam int ProdW    = SampleW + CntW;
  localparam int DivW     = ProdW + FracBits;
  localparam int QuotW    = SampleW + 1;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgKnownRows = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNumCols   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNormEn    = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic StatOk   = 1'b0;
  localparam logic StatMiss = 1'b1;

  // value of a known (bit 0) position: 2.0 in Q5.10
  localparam logic signed [SampleW-1:0] KnownLlr = SampleW'(2 ** (FracBits + 1));

  typedef struct packed {
    logic                      op;
    logic signed [SampleW-1:0] x;
    logic [SampleW-1:0]        mag;
    logic                      last;
    logic [IdxW-1:0]           idx;
  } cmd_t;

  typedef struct packed {
    logic [PrefW-1:0] prefix_len;
    logic             norm_en;
  } cfg_t;

  typedef struct packed {
    logic [QuotW-1:0] quot;
    logic             ovf;
  } div_res_t;

endpackage

// ===== rtl/llrkp_ram.sv =====
module llrkp_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/llrkp_front.sv =====
module llrkp_front import llrkp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_op,
  input  logic signed [SampleW-1:0] in_llr_in,
  input  logic                      in_last,
  input  logic [IdxW-1:0]           in_index,
  input  logic                      cfg_wr_en,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgW-1:0]           cfg_wdata,
  output cmd_t                      cmd,
  output logic                      cmd_valid,
  input  logic                      cmd_pop,
  output cfg_t                      cfg
);

  logic [CfgW-1:0]  known_rows_r;
  logic [CfgW-1:0]  num_cols_r;
  logic             norm_en_r;
  logic [PrefW-1:0] prefix_r;

  cmd_t             q_r [QDepth];
  logic [QPtrW-1:0] wptr_r;
  logic [QPtrW-1:0] rptr_r;
  logic [QCntW-1:0] cnt_r;
  logic [QCntW-1:0] cnt_nxt;

  logic             push_ok;
  logic             pop_ok;
  logic [SampleW-1:0] ux;
  cmd_t             new_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_rows_r <= '0;
      num_cols_r   <= CfgW'(1);
      norm_en_r    <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CfgKnownRows: known_rows_r <= cfg_wdata;
        CfgNumCols:   num_cols_r   <= cfg_wdata;
        CfgNormEn:    norm_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
    end else begin
      prefix_r <= PrefW'(known_rows_r) * PrefW'(num_cols_r);
    end
  end

  assign cfg.prefix_len = prefix_r;
  assign cfg.norm_en    = norm_en_r;

  // classify: magnitude is taken here so the back end only adds it
  assign ux = in_llr_in;
  always_comb begin
    new_cmd.op   = in_op;
    new_cmd.x    = in_llr_in;
    new_cmd.mag  = ux[SampleW-1] ? (~ux + 1'b1) : ux;
    new_cmd.last = in_last;
    new_cmd.idx  = in_index;
  end

  assign in_full   = (cnt_r == QCntW'(QDepth));
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd       = q_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop_ok) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wptr_r] <= new_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCntW'(QDepth))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == QCntW'(QDepth)) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with count");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !cmd_pop) |=> in_full)
    else $error("queue lost an entry while full");
`endif

endmodule

// ===== rtl/llrkp_div.sv =====
module llrkp_div import llrkp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DivW-1:0]  dividend,
  input  logic [SumW-1:0]  divisor,
  output logic             done,
  output div_res_t         res
);

  localparam int StepW = $clog2(DivW);

  logic             busy_r;
  logic             done_r;
  logic [StepW-1:0] step_r;
  logic [DivW-1:0]  num_r;
  logic [SumW-1:0]  den_r;
  logic [SumW-1:0]  rem_r;
  logic [QuotW-1:0] quot_r;
  logic             ovf_r;

  logic [SumW:0]    trial;
  logic [SumW:0]    diff;
  logic             ge;

  // restoring division, one quotient bit per cycle, MSB first
  assign trial = {rem_r, num_r[DivW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= StepW'(DivW - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= dividend;
      den_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
      ovf_r  <= 1'b0;
    end else if (busy_r) begin
      num_r  <= {num_r[DivW-2:0], 1'b0};
      rem_r  <= ge ? diff[SumW-1:0] : trial[SumW-1:0];
      quot_r <= {quot_r[QuotW-2:0], ge};
      // any bit shifted out of the kept quotient means saturation
      ovf_r  <= ovf_r | quot_r[QuotW-1];
    end
  end

  assign done     = done_r;
  assign res.quot = quot_r;
  assign res.ovf  = ovf_r;

`ifndef ASSERT_OFF
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !$past(start)) |-> (rem_r < den_r))
    else $error("partial remainder not below divisor");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("done while still iterating");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== rtl/llrkp_back.sv =====
module llrkp_back import llrkp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  input  logic                      cmd_valid,
  output logic                      cmd_pop,
  input  cfg_t                      cfg,
  output logic signed [SampleW-1:0] out_llr_out,
  output logic                      out_status,
  output logic                      out_empty,
  input  logic                      out_pop
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDWAIT = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV    = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic [SumW-1:0]  sum_r, sum_nxt;
  logic             complete_r, complete_nxt;

  logic             is_pre_r, is_pre_nxt;
  logic [CntW-1:0]  n_r, n_nxt;
  logic [ProdW-1:0] prod_r, prod_nxt;
  logic             neg_r, neg_nxt;
  logic [SampleW-1:0] res_llr_r, res_llr_nxt;
  logic             res_stat_r, res_stat_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [SampleW-1:0] out_llr_r;
  logic             out_stat_r;
  logic             out_load;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [SampleW-1:0] ram_wdata;
  logic             ram_re;
  logic [IdxW-1:0]  ram_raddr;
  logic [SampleW-1:0] ram_rdata;

  logic             div_start;
  logic [DivW-1:0]  div_dividend;
  logic             div_done;
  div_res_t         div_res;

  logic [CntW-1:0]  eff_count;
  logic [SumW-1:0]  eff_sum;
  logic [SumW:0]    sum_add;
  logic [CntW-1:0]  pre_clip;
  logic [SampleW-1:0] rd_mag;
  logic             slot_free;

  localparam logic [QuotW-1:0] PosLim = QuotW'(2 ** (SampleW - 1) - 1);
  localparam logic [QuotW-1:0] NegLim = QuotW'(2 ** (SampleW - 1));

  llrkp_ram #(
    .Width (SampleW),
    .Depth (MaxElems)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  llrkp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sum_r),
    .done     (div_done),
    .res      (div_res)
  );

  // a load after a completed matrix starts over
  assign eff_count = complete_r ? '0 : count_r;
  assign eff_sum   = complete_r ? '0 : sum_r;
  assign sum_add   = {1'b0, eff_sum} + {{(SumW + 1 - SampleW){1'b0}}, cmd.mag};
  assign pre_clip  = (cfg.prefix_len >= {{(PrefW - CntW){1'b0}}, count_r}) ?
                     count_r : cfg.prefix_len[CntW-1:0];
  assign rd_mag    = ram_rdata[SampleW-1] ? (~ram_rdata + 1'b1) : ram_rdata;
  assign slot_free = !out_valid_r || out_pop;

  assign ram_wdata    = cmd.x;
  assign ram_waddr    = eff_count[IdxW-1:0];
  assign ram_raddr    = cmd.idx;
  assign div_dividend = {prod_r, {FracBits{1'b0}}};

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    complete_nxt = complete_r;
    is_pre_nxt   = is_pre_r;
    n_nxt        = n_r;
    prod_nxt     = prod_r;
    neg_nxt      = neg_r;
    res_llr_nxt  = res_llr_r;
    res_stat_nxt = res_stat_r;
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == OpLoad) begin
            count_nxt    = eff_count;
            sum_nxt      = eff_sum;
            complete_nxt = cmd.last;
            if (eff_count < CntW'(MaxElems)) begin
              ram_we    = 1'b1;
              count_nxt = eff_count + 1'b1;
              if ({{(PrefW - CntW){1'b0}}, eff_count} >= cfg.prefix_len) begin
                sum_nxt = sum_add[SumW] ? '1 : sum_add[SumW-1:0];
              end
            end
          end else if ({1'b0, cmd.idx} >= count_r) begin
            res_llr_nxt  = '0;
            res_stat_nxt = StatMiss;
            state_nxt    = S_OUT;
          end else begin
            ram_re     = 1'b1;
            is_pre_nxt = {{(PrefW - IdxW){1'b0}}, cmd.idx} < cfg.prefix_len;
            n_nxt      = count_r - pre_clip;
            state_nxt  = S_RDWAIT;
          end
        end
      end
      S_RDWAIT: begin
        res_stat_nxt = StatOk;
        if (is_pre_r) begin
          res_llr_nxt = KnownLlr;
          state_nxt   = S_OUT;
        end else if (!cfg.norm_en || sum_r == '0) begin
          res_llr_nxt = ram_rdata;
          state_nxt   = S_OUT;
        end else begin
          neg_nxt   = ram_rdata[SampleW-1];
          prod_nxt  = {{CntW{1'b0}}, rd_mag} * {{SampleW{1'b0}}, n_r};
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (!neg_r) begin
            res_llr_nxt = (div_res.ovf || div_res.quot > PosLim) ?
                          {1'b0, {(SampleW - 1){1'b1}}} : div_res.quot[SampleW-1:0];
          end else begin
            res_llr_nxt = (div_res.ovf || div_res.quot > NegLim) ?
                          {1'b1, {(SampleW - 1){1'b0}}} : (~div_res.quot[SampleW-1:0] + 1'b1);
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      complete_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      complete_r  <= complete_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_pre_r   <= is_pre_nxt;
    n_r        <= n_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    res_llr_r  <= res_llr_nxt;
    res_stat_r <= res_stat_nxt;
    if (out_load) begin
      out_llr_r  <= res_llr_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign out_llr_out = out_llr_r;
  assign out_status  = out_stat_r;
  assign out_empty   = !out_valid_r;

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxElems))
    else $error("loaded count beyond store depth");

  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE && cmd_valid && cmd.op == OpLoad))
    else $error("store written outside a load");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider result with no read waiting");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_pop) |=> (state_r == S_OUT))
    else $error("result left while output slot busy");
`endif

endmodule

// ===== rtl/llr_known_prefix_normalizer_unit.sv =====
// Channel   Ports                                        Handshake
// input     in_op in_llr_in in_last in_index             in_push / in_full
// result    out_llr_out out_status                       out_pop / out_empty
// config    cfg_index cfg_wdata                          cfg_wr_en
//
// In the back end a load is handled in IDLE; a miss read passes IDLE and OUT;
// a prefix or unscaled read IDLE, RDWAIT and OUT; a scaled read adds MUL and
// DIV for the serial divider (one quotient bit per cycle over a 39-bit dividend).
// Reset (rst_n low, synchronous) empties the command queue and output slot
// and clears count, sum and complete flag; the sample store is not cleared.
// A two-entry command queue lets input be taken while the back end works
// or a result waits for pop.
module llr_known_prefix_normalizer_unit import llrkp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_op,
  input  logic signed [SampleW-1:0] in_llr_in,
  input  logic                      in_last,
  input  logic [IdxW-1:0]           in_index,
  output logic signed [SampleW-1:0] out_llr_out,
  output logic                      out_status,
  output logic                      out_empty,
  input  logic                      out_pop,
  input  logic                      cfg_wr_en,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgW-1:0]           cfg_wdata
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  cfg_t cfg;

  llrkp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_op     (in_op),
    .in_llr_in (in_llr_in),
    .in_last   (in_last),
    .in_index  (in_index),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg)
  );

  llrkp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cfg         (cfg),
    .out_llr_out (out_llr_out),
    .out_status  (out_status),
    .out_empty   (out_empty),
    .out_pop     (out_pop)
  );

endmodule

// ===== tb/sv/tb_llr_known_prefix_normalizer_unit.sv =====
module tb_llr_known_prefix_normalizer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import llrkp_pkg::*;

  localparam int     WatchLimit  = 3000;
  localparam int     DrainCycles = 16;
  localparam int     TailCycles  = 60;
  localparam int     RandomItems = 400;
  localparam longint SumCap      = (longint'(1) << SumW) - 1;
  localparam longint LlrMax      = (longint'(1) << (SampleW - 1)) - 1;
  localparam longint LlrMin      = -(longint'(1) << (SampleW - 1));

  typedef struct packed {
    logic signed [SampleW-1:0] llr;
    logic                      status;
  } llr_result_t;

  // Tracks the matrix as loaded and predicts each read.
  class norm_llr_tracker;
    logic signed [SampleW-1:0] samples [MaxElems];
    int unsigned fill_cnt    = 0;
    longint      abs_total   = 0;
    bit          frame_done  = 0;
    longint      prefix_rows = 0;
    longint      row_cols    = 1;
    bit          scale_on    = 1;
    llr_result_t expected_llrs [$];
    int          errors      = 0;

    function void write_reg(logic [CfgIdxW-1:0] sel, logic [CfgW-1:0] val);
      case (sel)
        CfgKnownRows: prefix_rows = longint'(val);
        CfgNumCols:   row_cols = longint'(val);
        CfgNormEn:    scale_on = val[0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v);
      if (v > LlrMax) return LlrMax;
      if (v < LlrMin) return LlrMin;
      return v;
    endfunction

    function int pending();
      return expected_llrs.size();
    endfunction

    function void note_item(logic op, logic signed [SampleW-1:0] x, logic last,
                            logic [IdxW-1:0] idx);
      longint      val;
      longint      mag;
      longint      pre;
      longint      quot;
      llr_result_t r;
      if (op == OpLoad) begin
        // first load after a closed matrix starts over
        if (frame_done) begin
          fill_cnt = 0;
          abs_total = 0;
          frame_done = 0;
        end
        if (fill_cnt < MaxElems) begin
          samples[fill_cnt] = x;
          if (longint'(fill_cnt) >= prefix_rows * row_cols) begin
            val = longint'(x);
            abs_total += (val < 0) ? -val : val;
            if (abs_total > SumCap) abs_total = SumCap;
          end
          fill_cnt++;
        end
        if (last) frame_done = 1;
      end else begin
        r.status = StatOk;
        if (idx >= fill_cnt) begin
          r.llr = '0;
          r.status = StatMiss;
        end else begin
          pre = prefix_rows * row_cols;
          if (pre > fill_cnt) pre = fill_cnt;
          if (idx < pre) begin
            val = clamp(longint'(2) << FracBits);
          end else begin
            val = longint'(samples[idx]);
            if (scale_on && abs_total != 0) begin
              mag = (val < 0) ? -val : val;
              quot = ((mag * (longint'(fill_cnt) - pre)) << FracBits) / abs_total;
              val = clamp((val < 0) ? -quot : quot);
            end
          end
          r.llr = val[SampleW-1:0];
        end
        expected_llrs.push_back(r);
      end
    endfunction

    function void check_result(logic signed [SampleW-1:0] llr, logic status);
      llr_result_t e;
      if (expected_llrs.size() == 0) begin
        if (errors < 10)
          $display("%0t: result with none pending: llr %0d status %0d", $time, llr, status);
        errors++;
        return;
      end
      e = expected_llrs.pop_front();
      if (llr !== e.llr || status !== e.status) begin
        if (errors < 10)
          $display("%0t: mismatch: expected llr %0d status %0d, got llr %0d status %0d",
                   $time, e.llr, e.status, llr, status);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_push;
  logic                      in_full;
  logic                      in_op;
  logic signed [SampleW-1:0] in_llr_in;
  logic                      in_last;
  logic [IdxW-1:0]           in_index;
  logic signed [SampleW-1:0] out_llr_out;
  logic                      out_status;
  logic                      out_empty;
  logic                      out_pop;
  logic                      cfg_wr_en;
  logic [CfgIdxW-1:0]        cfg_index;
  logic [CfgW-1:0]           cfg_wdata;

  norm_llr_tracker tracker;
  int              items_sent = 0;
  int              idle_cycles = 0;
  bit              calm = 0;

  llr_known_prefix_normalizer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_op      (in_op),
    .in_llr_in  (in_llr_in),
    .in_last    (in_last),
    .in_index   (in_index),
    .out_llr_out(out_llr_out),
    .out_status (out_status),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, a few long ones; none while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SampleW-1:0] draw_sample(int style);
    int r;
    r = $urandom_range(0, 9);
    case (style)
      0: return SampleW'($urandom);
      1: return SampleW'(int'($urandom_range(0, 4000)) - 2000);
      default: begin
        // sparse: mostly zero with the odd extreme, drives saturation
        if (r == 0) return SampleW'(LlrMin);
        if (r == 1) return SampleW'(LlrMax);
        if (r == 2) return SampleW'($urandom);
        return '0;
      end
    endcase
  endfunction

  function automatic logic [IdxW-1:0] pick_index();
    int hi;
    hi = int'(tracker.fill_cnt) + 1;
    if (hi > MaxElems - 1) hi = MaxElems - 1;
    if ($urandom_range(0, 4) == 0) return IdxW'($urandom);
    return IdxW'($urandom_range(0, hi));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (out_pop && !out_empty) tracker.check_result(out_llr_out, out_status);
      if (in_push && !in_full) tracker.note_item(in_op, in_llr_in, in_last, in_index);
      if ((out_pop && !out_empty) || (in_push && !in_full)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("llr_known_prefix_normalizer_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int g;
    out_pop = 1'b0;
    wait (rst_n);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        @(negedge clk);
        out_pop = 1'b0;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk);
      out_pop = 1'b1;
    end
  end

  task automatic put_item(logic op, logic signed [SampleW-1:0] x, logic last,
                          logic [IdxW-1:0] idx);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_push = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push = 1'b1;
    in_op = op;
    in_llr_in = x;
    in_last = last;
    in_index = idx;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  task automatic load(logic signed [SampleW-1:0] x, logic last);
    put_item(OpLoad, x, last, IdxW'($urandom));
  endtask

  task automatic read_at(logic [IdxW-1:0] idx);
    put_item(OpRead, SampleW'($urandom), 1'($urandom_range(0, 1)), idx);
  endtask

  // loads cause no result, so give the back end time after the last read
  task automatic wait_drained();
    @(negedge clk);
    in_push = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] sel, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = sel;
    cfg_wdata = val;
    tracker.write_reg(sel, val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic configure(int kr, int nc, bit en);
    wait_drained();
    write_reg(CfgKnownRows, CfgW'(kr));
    write_reg(CfgNumCols, CfgW'(nc));
    write_reg(CfgNormEn, CfgW'(en));
  endtask

  task automatic run_matrix(int len, int style, bit close, int read_pct);
    int n_reads;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < read_pct) read_at(pick_index());
      load(draw_sample(style), close && i == len - 1);
    end
    n_reads = $urandom_range(3, 12);
    repeat (n_reads) read_at(pick_index());
  endtask

  initial begin
    int p;
    int len;
    int rand_start;
    tracker = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_op = OpLoad;
    in_llr_in = '0;
    in_last = 1'b0;
    in_index = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CfgKnownRows;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // prefix of three, read on an empty store, read before last
    configure(1, 3, 1);
    read_at(5);
    load(32767, 0);
    load(-32768, 0);
    load(7, 0);
    load(1024, 0);
    read_at(3);
    load(-1, 0);
    load(-32768, 1);
    read_at(0);
    read_at(2);
    read_at(3);
    read_at(4);
    read_at(5);
    read_at(6);
    read_at(4095);
    configure(1, 3, 0);
    read_at(3);
    read_at(5);
    // prefix longer than the matrix
    configure(4096, 1, 1);
    read_at(5);
    // zero columns: empty prefix
    configure(5, 0, 1);
    read_at(0);
    read_at(5);
    // load after last opens a new matrix
    load(100, 1);
    read_at(0);
    read_at(1);

    rand_start = items_sent;
    p = 0;
    while (items_sent - rand_start < RandomItems) begin
      calm = (p % 4 == 3);
      case (p)
        0: configure(4096, 4096, 1);
        1: configure($urandom_range(1, 3), 0, 0);
        2: configure(8191, 8191, 1);
        3: configure(0, 1, 1);
        default: configure($urandom_range(0, 4), $urandom_range(1, 10),
                           $urandom_range(0, 3) != 0);
      endcase
      repeat ($urandom_range(2, 4)) begin
        if (items_sent - rand_start < RandomItems) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
          run_matrix(len, $urandom_range(0, 2), $urandom_range(0, 9) != 0, 10);
        end
      end
      p++;
    end
    calm = 0;

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("llr_known_prefix_normalizer_unit test passed");
    else
      $display("llr_known_prefix_normalizer_unit test failed");
    $finish;
  end

endmodule
